[hdl/bilinear_integer_upscaler_core_assert.svh]
// Assertion macros shared by the upscaler RTL.
`ifndef BILINEAR_INTEGER_UPSCALER_CORE_ASSERT_SVH
`define BILINEAR_INTEGER_UPSCALER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/biu_pkg.sv]
// Shared types and constants of the bilinear upscaler.
`timescale 1ns / 1ps
package biu_pkg;

    localparam int PIX_W      = 8;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 12;
    localparam int OROW_W     = 14;
    localparam int OCOL_W     = 12;
    localparam int FAC_W      = 3;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CFG_W      = 13;
    localparam int IDX_W      = 2;
    localparam int MAX_HEIGHT = 4096;
    localparam int TDATA_W    = 40;

    typedef enum logic [IDX_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FE_IDLE,
        FE_LOOKUP,
        FE_EMIT
    } fe_state_t;

    // One output tile: anchor position and the four corner pixels.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
        logic [PIX_W-1:0] d;
        logic             last;
    } tile_t;

endpackage

[hdl/biu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module biu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/biu_tile_fifo.sv]
// Short tile queue between the front and back parts.
`timescale 1ns / 1ps
module biu_tile_fifo #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  biu_pkg::tile_t wdata,
    input  logic          pop,
    output biu_pkg::tile_t rdata,
    output logic          full,
    output logic          empty
);
    import biu_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tile_t         mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign rdata = mem_reg[rptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

[hdl/biu_front.sv]
// Front part: configuration, pixel intake, line buffer and tile classification.
`timescale 1ns / 1ps
module biu_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [biu_pkg::IDX_W-1:0]    cfg_index,
    input  logic [biu_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [biu_pkg::PIX_W-1:0]    pixel,
    output logic [biu_pkg::FAC_W-1:0]    factor,
    output logic                         tile_push,
    output biu_pkg::tile_t               tile,
    input  logic                         fifo_full
);
    import biu_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam logic [FAC_W-1:0] FAC_RESET = FAC_W'((MAX_FACTOR < 2) ? MAX_FACTOR : 2);
    localparam logic [WW-1:0]    WID_RESET = WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);

    fe_state_t         state_reg, state_next;
    logic [FAC_W-1:0]  fac_reg, fac_next;
    logic [WW-1:0]     wid_reg, wid_next;
    logic [HGT_W-1:0]  hgt_reg, hgt_next;
    logic              restart;

    logic [AW-1:0]     col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PIX_W-1:0]  lc_reg, lp_reg;
    logic [3:0]        mask_reg;
    logic [3:0]        mask_rest;

    logic [PIX_W-1:0]  px_reg, lch_reg, lph_reg, up_reg;
    logic [AW-1:0]     acol_reg;
    logic [ROW_W-1:0]  arow_reg;
    logic              lastc_reg;

    logic              accept;
    logic              last_col, last_row;
    logic              ram_we;
    logic [PIX_W-1:0]  ram_rdata;
    logic [COL_W-1:0]  tcol;

    // Configuration decode, with out-of-range values held to the legal range
    always_comb
    begin
        fac_next = fac_reg;
        wid_next = wid_reg;
        hgt_next = hgt_reg;
        restart  = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SCALE:
                begin
                    restart = 1'b1;
                    if (cfg_data[FAC_W-1:0] == '0)
                        fac_next = FAC_W'(1);
                    else if (cfg_data[FAC_W-1:0] > MAX_FACTOR)
                        fac_next = FAC_W'(MAX_FACTOR);
                    else
                        fac_next = cfg_data[FAC_W-1:0];
                end
                REG_WIDTH:
                begin
                    restart = 1'b1;
                    if (cfg_data[WID_W-1:0] == '0)
                        wid_next = WW'(1);
                    else if (cfg_data[WID_W-1:0] > MAX_WIDTH)
                        wid_next = WW'(MAX_WIDTH);
                    else
                        wid_next = WW'(cfg_data[WID_W-1:0]);
                end
                REG_HEIGHT:
                begin
                    restart = 1'b1;
                    if (cfg_data[HGT_W-1:0] == '0)
                        hgt_next = HGT_W'(1);
                    else if (cfg_data[HGT_W-1:0] > MAX_HEIGHT)
                        hgt_next = HGT_W'(MAX_HEIGHT);
                    else
                        hgt_next = cfg_data[HGT_W-1:0];
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    assign factor   = fac_reg;
    assign accept   = s_tvalid && s_tready;
    assign last_col = (WW'(col_reg) == wid_reg - WW'(1));
    assign last_row = (HGT_W'(row_reg) == hgt_reg - HGT_W'(1));
    assign mask_rest = mask_reg & (mask_reg - 4'd1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE:
            begin
                if (accept)
                    state_next = FE_LOOKUP;
            end
            FE_LOOKUP:
            begin
                state_next = (mask_reg != '0) ? FE_EMIT : FE_IDLE;
            end
            FE_EMIT:
            begin
                if (!fifo_full && mask_rest == '0)
                    state_next = FE_IDLE;
            end
            default:
            begin
                state_next = FE_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        tile_push = 1'b0;
        case (state_reg)
            FE_IDLE:   s_tready  = 1'b1;
            FE_LOOKUP: ram_we    = 1'b1;
            FE_EMIT:   tile_push = !fifo_full;
            default:   s_tready  = 1'b0;
        endcase
    end

    // Pick the lowest pending tile; corner pixels past the edges are zero
    assign tcol = COL_W'(acol_reg);
    always_comb
    begin
        tile.last = (mask_rest == '0);
        if (mask_reg[0])
        begin
            tile.row = arow_reg - ROW_W'(1);
            tile.col = tcol - COL_W'(1);
            tile.a   = lph_reg;
            tile.b   = up_reg;
            tile.c   = lch_reg;
            tile.d   = px_reg;
        end
        else if (mask_reg[1])
        begin
            tile.row = arow_reg - ROW_W'(1);
            tile.col = tcol;
            tile.a   = up_reg;
            tile.b   = '0;
            tile.c   = px_reg;
            tile.d   = '0;
        end
        else if (mask_reg[2])
        begin
            tile.row = arow_reg;
            tile.col = tcol - COL_W'(1);
            tile.a   = lch_reg;
            tile.b   = px_reg;
            tile.c   = '0;
            tile.d   = '0;
        end
        else
        begin
            tile.row = arow_reg;
            tile.col = tcol;
            tile.a   = px_reg;
            tile.b   = '0;
            tile.c   = '0;
            tile.d   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_IDLE;
            fac_reg   <= FAC_RESET;
            wid_reg   <= WID_RESET;
            hgt_reg   <= HGT_W'(768);
            col_reg   <= '0;
            row_reg   <= '0;
            lc_reg    <= '0;
            lp_reg    <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fac_reg   <= fac_next;
            wid_reg   <= wid_next;
            hgt_reg   <= hgt_next;
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                lc_reg  <= '0;
                lp_reg  <= '0;
            end
            else if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                    lc_reg  <= '0;
                end
                else
                begin
                    col_reg <= col_reg + AW'(1);
                    lc_reg  <= pixel;
                end
            end
            else if (state_reg == FE_LOOKUP)
            begin
                lp_reg <= lastc_reg ? '0 : ram_rdata;
            end
            if (accept)
            begin
                mask_reg <= {last_row && last_col,
                             last_row && (col_reg != '0),
                             (row_reg != '0) && last_col,
                             (row_reg != '0) && (col_reg != '0)};
            end
            else if (tile_push)
            begin
                mask_reg <= mask_rest;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg    <= pixel;
            lph_reg   <= lp_reg;
            lch_reg   <= lc_reg;
            acol_reg  <= col_reg;
            arow_reg  <= row_reg;
            lastc_reg <= last_col;
        end
        if (state_reg == FE_LOOKUP)
        begin
            up_reg <= ram_rdata;
        end
    end

    // Line buffer: read at intake, write the new pixel back in the lookup cycle after it
    biu_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (acol_reg),
        .wdata (px_reg),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

endmodule

[hdl/biu_back.sv]
// Back part: walks each tile and computes the interpolated pixels in a short pipeline.
`timescale 1ns / 1ps
module biu_back #(
    parameter int MAX_FACTOR = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [biu_pkg::FAC_W-1:0]   factor,
    input  biu_pkg::tile_t              tile,
    input  logic                        fifo_empty,
    output logic                        tile_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [biu_pkg::TDATA_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import biu_pkg::*;

    localparam int KW     = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int TOP_W  = PIX_W + 2;
    localparam int NUM_W  = PIX_W + 4;
    localparam int POS_W  = ROW_W + FAC_W;
    localparam int RCP_W  = 13;
    localparam int PROD_W = NUM_W + RCP_W;
    // 2^16 / 9 rounded up; exact for every numerator below 2^12
    localparam logic [RCP_W-1:0] RECIP_NINE = 13'd7282;

    logic              adv;

    // Tile walker
    tile_t             tile_reg, tile_next;
    logic              busy_reg, busy_next;
    logic [KW-1:0]     ky_reg, ky_next, kx_reg, kx_next;
    logic              issue, final_elem, load;

    // Stage one: row products
    logic              s1_valid_reg;
    logic [OROW_W-1:0] s1_row_reg;
    logic [OCOL_W-1:0] s1_col_reg;
    logic [TOP_W-1:0]  s1_top_reg, s1_bot_reg;
    logic [KW-1:0]     s1_ky_reg;
    logic              s1_last_reg;

    // Stage two: weighted numerator
    logic              s2_valid_reg;
    logic [OROW_W-1:0] s2_row_reg;
    logic [OCOL_W-1:0] s2_col_reg;
    logic [NUM_W-1:0]  s2_num_reg;
    logic              s2_last_reg;

    // Output register
    logic              out_valid_reg;
    logic [OROW_W-1:0] out_row_reg;
    logic [OCOL_W-1:0] out_col_reg;
    logic [PIX_W-1:0]  out_value_reg;
    logic              out_last_reg;

    logic [FAC_W-1:0]  wx0, wx1, wy0, wy1;
    logic [TOP_W:0]    top_full, bot_full;
    logic [POS_W-1:0]  row_full, col_full;
    logic [5:0]        sq;
    logic [NUM_W+1:0]  num_full;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  quot;

    assign adv        = !out_valid_reg || m_tready;
    assign issue      = busy_reg && adv;
    assign final_elem = (FAC_W'(ky_reg) == factor - FAC_W'(1))
                     && (FAC_W'(kx_reg) == factor - FAC_W'(1));
    assign load       = !busy_reg || (issue && final_elem);
    assign tile_pop   = load && !fifo_empty;

    always_comb
    begin
        tile_next = tile_reg;
        busy_next = busy_reg;
        ky_next   = ky_reg;
        kx_next   = kx_reg;
        if (load)
        begin
            tile_next = tile;
            busy_next = !fifo_empty;
            ky_next   = '0;
            kx_next   = '0;
        end
        else if (issue)
        begin
            if (FAC_W'(kx_reg) == factor - FAC_W'(1))
            begin
                kx_next = '0;
                ky_next = ky_reg + KW'(1);
            end
            else
            begin
                kx_next = kx_reg + KW'(1);
            end
        end
    end

    // Stage one arithmetic
    assign wx1 = FAC_W'(kx_reg);
    assign wx0 = factor - wx1;
    assign top_full = (TOP_W+1)'(wx0) * (TOP_W+1)'(tile_reg.a)
                    + (TOP_W+1)'(wx1) * (TOP_W+1)'(tile_reg.b);
    assign bot_full = (TOP_W+1)'(wx0) * (TOP_W+1)'(tile_reg.c)
                    + (TOP_W+1)'(wx1) * (TOP_W+1)'(tile_reg.d);
    assign row_full = POS_W'(tile_reg.row) * POS_W'(factor) + POS_W'(ky_reg);
    assign col_full = POS_W'(tile_reg.col) * POS_W'(factor) + POS_W'(kx_reg);

    // Stage two arithmetic: add half the divisor for round to nearest
    assign wy1 = FAC_W'(s1_ky_reg);
    assign wy0 = factor - wy1;
    assign sq  = 6'(factor) * 6'(factor);
    assign num_full = (NUM_W+2)'(wy0) * (NUM_W+2)'(s1_top_reg)
                    + (NUM_W+2)'(wy1) * (NUM_W+2)'(s1_bot_reg)
                    + (NUM_W+2)'(sq >> 1);

    // Stage three: divide by factor squared
    assign prod = PROD_W'(s2_num_reg) * PROD_W'(RECIP_NINE);
    always_comb
    begin
        case (factor)
            3'd2:    quot = s2_num_reg >> 2;
            3'd3:    quot = NUM_W'(prod[PROD_W-1:16]);
            3'd4:    quot = s2_num_reg >> 4;
            default: quot = s2_num_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ky_reg        <= '0;
            kx_reg        <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ky_reg   <= ky_next;
            kx_reg   <= kx_next;
            if (adv)
            begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tile_reg <= tile_next;
        if (adv)
        begin
            s1_row_reg    <= row_full[OROW_W-1:0];
            s1_col_reg    <= col_full[OCOL_W-1:0];
            s1_top_reg    <= top_full[TOP_W-1:0];
            s1_bot_reg    <= bot_full[TOP_W-1:0];
            s1_ky_reg     <= ky_reg;
            s1_last_reg   <= tile_reg.last && final_elem;
            s2_row_reg    <= s1_row_reg;
            s2_col_reg    <= s1_col_reg;
            s2_num_reg    <= num_full[NUM_W-1:0];
            s2_last_reg   <= s1_last_reg;
            out_row_reg   <= s2_row_reg;
            out_col_reg   <= s2_col_reg;
            out_value_reg <= (quot > NUM_W'(255)) ? 8'd255 : quot[PIX_W-1:0];
            out_last_reg  <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(TDATA_W - OROW_W - OCOL_W - PIX_W)'(0),
                       out_value_reg, out_col_reg, out_row_reg};

endmodule

[hdl/bilinear_integer_upscaler_core.sv]
// Top level of the streaming bilinear integer upscaler.
//
//  Channel  Direction  Carries
//  s_*      in         grey input pixel, raster order (tdata[7:0])
//  m_*      out        one upscaled pixel per transaction, tlast on a pixel's final result
//  cfg_*    in         register write: 0 scale_factor, 1 frame_width, 2 frame_height
//
// The front takes a pixel by intake and a line-buffer read, then pushes up to four tiles
// for it. The back emits one result per cycle while the output is ready and a tile
// waits, F*F per tile, so a pixel usually costs one tile. Each result of a popped tile
// passes the walker, stage one, stage two and output registers. A stalled output holds
// the back pipeline; the front keeps going until the tile queue fills. Reset restores
// the register defaults and a fresh frame; row 0 refills the line buffer.
`timescale 1ns / 1ps
`include "bilinear_integer_upscaler_core_assert.svh"
module bilinear_integer_upscaler_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_FACTOR = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port
    input  logic                        cfg_we,
    input  logic [biu_pkg::IDX_W-1:0]   cfg_index,
    input  logic [biu_pkg::CFG_W-1:0]   cfg_data,
    // Pixel input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [biu_pkg::PIX_W-1:0]   s_tdata,  // [7:0] pixel_value
    // Result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [biu_pkg::TDATA_W-1:0] m_tdata,  // [13:0] out_row, [25:14] out_col,
                                                  // [33:26] out_value, [39:34] zero
    output logic                        m_tlast   // last_of_run
);
    import biu_pkg::*;

    localparam int QUEUE_DEPTH = 4;

    logic [FAC_W-1:0] factor;
    logic             tile_push, tile_pop;
    logic             fifo_full, fifo_empty;
    tile_t            push_tile, head_tile;

    // Front: configuration, intake, line buffer, tile classification
    biu_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pixel     (s_tdata),
        .factor    (factor),
        .tile_push (tile_push),
        .tile      (push_tile),
        .fifo_full (fifo_full)
    );

    // Tile queue: decouple intake from result emission
    biu_tile_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (tile_push),
        .wdata (push_tile),
        .pop   (tile_pop),
        .rdata (head_tile),
        .full  (fifo_full),
        .empty (fifo_empty)
    );

    // Back: walk each tile and compute its pixels
    biu_back #(
        .MAX_FACTOR (MAX_FACTOR)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .factor     (factor),
        .tile       (head_tile),
        .fifo_empty (fifo_empty),
        .tile_pop   (tile_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Intake closes for the line-buffer read after every pixel
    `BIU_ASSERT_NEXT(a_single_intake, s_tvalid && s_tready, !s_tready, "pixel taken during lookup")
    // The front never pushes into a full queue
    `BIU_ASSERT_SAME(a_push_not_full, tile_push, !fifo_full, "tile pushed into full queue")
    // The back never pops an empty queue
    `BIU_ASSERT_SAME(a_pop_not_empty, tile_pop, !fifo_empty, "tile popped from empty queue")

endmodule

[sim/bilinear_integer_upscaler_core_test.sv]
// Self-checking testbench for the streaming bilinear integer upscaler core.
`timescale 1ns / 1ps
module bilinear_integer_upscaler_core_test;
    import biu_pkg::*;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_FACTOR   = 4;
    localparam int COL_AW       = $clog2(MAX_WIDTH);
    localparam int RANDOM_ITEMS = 215;
    localparam int DRAIN_CYCLES = 40;     // well past the intake and emit latency
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_CAP   = 30;
    localparam int PAD_W        = TDATA_W - OROW_W - OCOL_W - PIX_W;

    // Unmapped register index: the block drops writes to it.
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

    // One upscaled pixel laid out exactly as {m_tlast, m_tdata}.
    typedef struct packed {
        logic              last;
        logic [PAD_W-1:0]  pad;
        logic [PIX_W-1:0]  value;
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
    } upscaled_pixel_t;

    typedef enum logic [1:0] {
        ROW_CONFIG,      // register write, index and data
        ROW_PIXEL,       // pixel, results from the predictor
        ROW_PIXEL_NONE,  // pixel that completes no tile
        ROW_PIXEL_ONE    // pixel with one result typed in below
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [IDX_W-1:0]  index;
        logic [CFG_W-1:0]  data;
        logic [OROW_W-1:0] exp_row;
        logic [OCOL_W-1:0] exp_col;
        logic [PIX_W-1:0]  exp_value;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 22;

    // Directed part. Reset leaves F = 2 and a 1024 x 768 frame, so the first two pixels
    // sit on row 0 and complete nothing. A 1 x 1 frame at F = 1 echoes each pixel.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_PIXEL_NONE, REG_SCALE,  13'h05A, 14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL_NONE, REG_SCALE,  13'h0A5, 14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_SCALE,  13'd1,   14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_WIDTH,  13'd1,   14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_HEIGHT, 13'd1,   14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL_ONE,  REG_SCALE,  13'h000, 14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL_ONE,  REG_SCALE,  13'h0FF, 14'd0, 12'd0, 8'hFF},
        '{ROW_PIXEL_ONE,  REG_SCALE,  13'h055, 14'd0, 12'd0, 8'h55},
        '{ROW_PIXEL_ONE,  REG_SCALE,  13'h0AA, 14'd0, 12'd0, 8'hAA},
        // factor 0 behaves as 1
        '{ROW_CONFIG,     REG_SCALE,  13'd0,   14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL_ONE,  REG_SCALE,  13'h081, 14'd0, 12'd0, 8'h81},
        // largest factor; zero width and height behave as 1
        '{ROW_CONFIG,     REG_SCALE,  13'd4,   14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_WIDTH,  13'd0,   14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_HEIGHT, 13'd0,   14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL,      REG_SCALE,  13'h0FF, 14'd0, 12'd0, 8'h00},
        // factor above the maximum behaves as 4; a 2 x 2 frame hits all four tile
        // cases, and its last pixel gives the full 64 results
        '{ROW_CONFIG,     REG_SCALE,  13'd7,   14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_WIDTH,  13'd2,   14'd0, 12'd0, 8'h00},
        '{ROW_CONFIG,     REG_HEIGHT, 13'd2,   14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL,      REG_SCALE,  13'h0FF, 14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL,      REG_SCALE,  13'h000, 14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL,      REG_SCALE,  13'h07F, 14'd0, 12'd0, 8'h00},
        '{ROW_PIXEL,      REG_SCALE,  13'h080, 14'd0, 12'd0, 8'h00}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [PIX_W-1:0]     s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;

    // Predictor copy of the registers and of the frame state.
    logic [FAC_W-1:0]     scale_reg;
    logic [WID_W-1:0]     width_reg;
    logic [HGT_W-1:0]     height_reg;
    logic [PIX_W-1:0]     prev_row_buf [MAX_WIDTH];
    logic [PIX_W-1:0]     left_now;
    logic [PIX_W-1:0]     left_above;
    int unsigned          next_row;
    int unsigned          next_col;

    upscaled_pixel_t      pending_pixels [$];
    int unsigned          fail_count = 0;
    int unsigned          burst_left = 0;
    int unsigned          cycle_count = 0;
    bit                   hold_wanted = 1'b0;
    bit                   hold_served = 1'b0;

    bilinear_integer_upscaler_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // A write to a mapped register restarts the frame; the line buffer survives.
    function automatic void apply_reg_write(logic [IDX_W-1:0] index, logic [CFG_W-1:0] data);
        case (index)
            REG_SCALE:  scale_reg  = data[FAC_W-1:0];
            REG_WIDTH:  width_reg  = data[WID_W-1:0];
            REG_HEIGHT: height_reg = data[HGT_W-1:0];
            default:    return;
        endcase
        next_row   = 0;
        next_col   = 0;
        left_now   = '0;
        left_above = '0;
    endfunction

    // Queue the F x F tile anchored at input pixel (r, c) with corners a b / cl d,
    // ky outer and kx inner; rounding is to nearest with ties upward.
    function automatic void interpolate_tile(int unsigned r, int unsigned c, int unsigned a,
                                             int unsigned b, int unsigned cl, int unsigned d,
                                             int unsigned f);
        upscaled_pixel_t res;
        int unsigned     ky;
        int unsigned     kx;
        int unsigned     top;
        int unsigned     bottom;
        int unsigned     v;
        for (ky = 0; ky < f; ky++)
        begin
            for (kx = 0; kx < f; kx++)
            begin
                top       = (f - kx) * a + kx * b;
                bottom    = (f - kx) * cl + kx * d;
                v         = ((f - ky) * top + ky * bottom + f * f / 2) / (f * f);
                res.last  = 1'b0;
                res.pad   = '0;
                res.value = (v > 255) ? 8'hFF : PIX_W'(v);
                res.col   = OCOL_W'(c * f + kx);
                res.row   = OROW_W'(r * f + ky);
                pending_pixels.push_back(res);
            end
        end
    endfunction

    // Advance the frame by one input pixel; return how many results it queued.
    function automatic int interpolate_pixel(logic [PIX_W-1:0] px);
        int unsigned f;
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned above;
        bit          last_col;
        bit          last_row;
        int          first;
        int          n;
        f        = clamp_range(32'(scale_reg), 1, MAX_FACTOR);
        w        = clamp_range(32'(width_reg), 1, MAX_WIDTH);
        h        = clamp_range(32'(height_reg), 1, MAX_HEIGHT);
        r        = (next_row >= h) ? h - 1 : next_row;
        c        = (next_col >= w) ? w - 1 : next_col;
        last_col = (c == w - 1);
        last_row = (r == h - 1);
        above    = 32'(prev_row_buf[COL_AW'(c)]);
        first    = pending_pixels.size();
        if (r >= 1 && c >= 1)
            interpolate_tile(r - 1, c - 1, 32'(left_above), above, 32'(left_now), 32'(px), f);
        if (r >= 1 && last_col)
            interpolate_tile(r - 1, c, above, 0, 32'(px), 0, f);
        if (last_row && c >= 1)
            interpolate_tile(r, c - 1, 32'(left_now), 32'(px), 0, 0, f);
        if (last_row && last_col)
            interpolate_tile(r, c, 32'(px), 0, 0, 0, f);
        n = pending_pixels.size() - first;
        if (n > 0)
            pending_pixels[pending_pixels.size() - 1].last = 1'b1;
        left_above               = PIX_W'(above);
        left_now                 = px;
        prev_row_buf[COL_AW'(c)] = px;
        if (last_col)
        begin
            next_col   = 0;
            next_row   = last_row ? 0 : r + 1;
            left_above = '0;
            left_now   = '0;
        end
        else
        begin
            next_col = c + 1;
            next_row = r;
        end
        return n;
    endfunction

    // Offer one pixel and hold it until the transaction completes. Valid stays high on
    // return: the caller either offers the next pixel at the coming falling edge or
    // drops valid there, through wait_idle or the gap before the next pixel.
    task automatic feed_pixel(input logic [PIX_W-1:0] px, output int produced);
        int unsigned gap;
        if (burst_left == 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = px;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        burst_left--;
        produced = interpolate_pixel(px);
    endtask

    // Drop valid, let every expected result arrive, then let the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        apply_reg_write(index, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One random phase: fresh registers, then a run of pixels. Phase 1 also asks the
    // receiver for a long hold-off; phases 3 and 5 take a row width and a frame height
    // at or above the largest legal size, both held to it.
    task automatic run_phase(input int unsigned phase, output int unsigned fed);
        logic [CFG_W-1:0] scale_word;
        logic [CFG_W-1:0] width_word;
        logic [CFG_W-1:0] height_word;
        logic [PIX_W-1:0] px;
        int unsigned      area;
        int unsigned      count;
        int unsigned      pick;
        int               produced;

        scale_word = CFG_W'($urandom_range(1, 4));
        if ($urandom_range(0, 7) == 0)
            scale_word = CFG_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 7));
        if ($urandom_range(0, 3) == 0)
            scale_word[CFG_W-1:FAC_W] = (CFG_W-FAC_W)'($urandom);  // junk above is dropped
        width_word = CFG_W'($urandom_range(1, 6));
        if ($urandom_range(0, 9) == 0)
            width_word = CFG_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1025, 2047));
        if ($urandom_range(0, 3) == 0)
            width_word[CFG_W-1:WID_W] = (CFG_W-WID_W)'($urandom);
        height_word = CFG_W'($urandom_range(1, 5));
        if ($urandom_range(0, 9) == 0)
            height_word = CFG_W'(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(4096, 8191));

        case (phase)
            1:
            begin
                scale_word  = CFG_W'(4);
                width_word  = CFG_W'(6);
                height_word = CFG_W'(5);
            end
            3:
            begin
                scale_word  = CFG_W'(1);
                width_word  = CFG_W'(MAX_WIDTH + $urandom_range(0, MAX_WIDTH - 1));
                height_word = CFG_W'(1);
            end
            5:
            begin
                scale_word  = CFG_W'($urandom_range(1, 4));
                width_word  = CFG_W'(1);
                height_word = CFG_W'(MAX_HEIGHT + $urandom_range(0, MAX_HEIGHT - 1));
            end
            default: ;
        endcase

        area = clamp_range(32'(width_word[WID_W-1:0]), 1, MAX_WIDTH)
             * clamp_range(32'(height_word[HGT_W-1:0]), 1, MAX_HEIGHT);
        if (phase == 1)
            count = area;
        else if (phase == 5)
            count = 24;
        else if (area > 60)
            count = $urandom_range(1, 16);         // huge frame: a short partial run
        else if ($urandom_range(0, 5) == 0)
            count = $urandom_range(1, area);       // broken-off frame
        else
            count = area * $urandom_range(1, 2);   // whole frames, sometimes wrapping

        wait_idle();
        if ($urandom_range(0, 4) == 0)
            write_reg(REG_SPARE, CFG_W'($urandom));
        write_reg(REG_SCALE, scale_word);
        write_reg(REG_WIDTH, width_word);
        write_reg(REG_HEIGHT, height_word);
        if (phase == 1)
            hold_wanted = 1'b1;

        repeat (count)
        begin
            pick = $urandom_range(0, 9);
            px   = (pick == 0) ? 8'h00 : ((pick == 1) ? 8'hFF : PIX_W'($urandom));
            feed_pixel(px, produced);
        end
        fed = count;
    endtask

    // Stimulus: reset, directed table, random phases, drain and verdict.
    initial
    begin
        int unsigned random_items;
        int unsigned phase;
        int unsigned fed;
        int          produced;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_SCALE;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        scale_reg  = FAC_W'(2);
        width_reg  = WID_W'(1024);
        height_reg = HGT_W'(768);
        foreach (prev_row_buf[i])
            prev_row_buf[i] = '0;
        left_now   = '0;
        left_above = '0;
        next_row   = 0;
        next_col   = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CONFIG)
            begin
                wait_idle();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                feed_pixel(directed_rows[i].data[PIX_W-1:0], produced);
                // Typed rows replace what the predictor queued for this pixel.
                if (directed_rows[i].kind != ROW_PIXEL)
                begin
                    repeat (produced)
                        pending_pixels.delete(pending_pixels.size() - 1);
                    if (directed_rows[i].kind == ROW_PIXEL_ONE)
                        pending_pixels.push_back('{1'b1, '0, directed_rows[i].exp_value,
                                                   directed_rows[i].exp_col,
                                                   directed_rows[i].exp_row});
                end
            end
        end

        random_items = 0;
        phase        = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            run_phase(phase, fed);
            random_items += fed;
            phase++;
        end

        wait_idle();
        if (fail_count == 0)
            $display("** bilinear_integer_upscaler_core: PASSED **");
        else
            $display("** bilinear_integer_upscaler_core: FAILED **");
        $finish;
    end

    // Receiver: stall on random patterns that change after each random span, including
    // stretches of constant readiness, plus one long hold-off on request.
    initial
    begin
        int unsigned mode;
        int unsigned span;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            repeat (span)
            begin
                @(negedge clk);
                if (hold_wanted && !hold_served)
                begin
                    // hold off the results so the tile queue fills and the input stalls
                    m_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_served = 1'b1;
                end
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare every result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        upscaled_pixel_t got;
        upscaled_pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tlast, m_tdata};
            if (pending_pixels.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: unexpected result row %0d col %0d value %0d last %0b",
                             $time, got.row, got.col, got.value, got.last);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                        $display({"%0t: expected row %0d col %0d value %0d last %0b pad %0h,",
                                  " got row %0d col %0d value %0d last %0b pad %0h"},
                                 $time, want.row, want.col, want.value, want.last, want.pad,
                                 got.row, got.col, got.value, got.last, got.pad);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: cycle limit reached with %0d results outstanding",
                 $time, pending_pixels.size());
        $display("** bilinear_integer_upscaler_core: FAILED **");
        $finish;
    end

endmodule
